// ----- src/srps_pkg.sv -----
// ----------------------------------------------------------------------------
// srps_pkg: shared types and constants for the serial record/playback store
// Mode codes, queue command kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package srps_pkg;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_PLAYBACK  = 2'd2
  } mode_t;

  // Commands passed from the front end to the store side
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,  // store data at addr
    CMD_SEND  = 2'd1,  // transmit data as is
    CMD_READ  = 2'd2   // transmit store[addr]
  } cmd_kind_t;

  localparam int unsigned CMD_KIND_W = 2;

  // Configuration register indexes
  localparam logic CFG_TOGGLE_IDX = 1'b0;
  localparam logic CFG_PLAY_IDX   = 1'b1;

  localparam logic [7:0] TOGGLE_CODE_RST = 8'h1A;
  localparam logic [7:0] PLAY_CODE_RST   = 8'h19;
  localparam logic [7:0] ERASED_BYTE     = 8'hFF;
  localparam logic [7:0] NO_BYTE         = 8'h00;

endpackage

// ----- src/srps_front.sv -----
// ----------------------------------------------------------------------------
// srps_front: event classifier
// Holds mode, held byte, addresses and control codes; turns each event into
// at most one store command.
// ----------------------------------------------------------------------------
module srps_front #(
  parameter int unsigned STORE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  ev_take,
  input  logic                  ev_operation,
  input  logic [7:0]            ev_rx_byte,
  output logic                  cmd_push,
  output srps_pkg::cmd_kind_t   cmd_kind,
  output logic [AW-1:0]         cmd_addr,
  output logic [7:0]            cmd_data
);

  logic [7:0]          toggle_code_r;
  logic [7:0]          play_code_r;
  srps_pkg::mode_t     mode_r, mode_nxt;
  logic [7:0]          held_r, held_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic                armed_r, armed_nxt;
  logic                wr_last, rd_last;

  assign wr_last = (wr_addr_r == AW'(STORE_DEPTH - 1));
  assign rd_last = (rd_addr_r == AW'(STORE_DEPTH - 1));

  always_comb begin
    mode_nxt    = mode_r;
    held_nxt    = held_r;
    wr_addr_nxt = wr_addr_r;
    rd_addr_nxt = rd_addr_r;
    wrapped_nxt = wrapped_r;
    armed_nxt   = armed_r;
    cmd_push    = 1'b0;
    cmd_kind    = srps_pkg::CMD_SEND;
    cmd_addr    = wr_addr_r;
    cmd_data    = held_r;
    if (ev_take) begin
      if (!ev_operation) begin
        held_nxt  = ev_rx_byte;
        armed_nxt = 1'b1;
        if (ev_rx_byte == toggle_code_r) begin
          mode_nxt = (mode_r == srps_pkg::MODE_RECORDING) ? srps_pkg::MODE_STOPPED
                                                          : srps_pkg::MODE_RECORDING;
          held_nxt = srps_pkg::NO_BYTE;
        end else if (ev_rx_byte == play_code_r && mode_r != srps_pkg::MODE_PLAYBACK) begin
          mode_nxt = srps_pkg::MODE_PLAYBACK;
          held_nxt = srps_pkg::NO_BYTE;
        end
        if (held_nxt != srps_pkg::NO_BYTE && mode_nxt == srps_pkg::MODE_RECORDING) begin
          cmd_push    = 1'b1;
          cmd_kind    = srps_pkg::CMD_WRITE;
          cmd_addr    = wr_addr_r;
          cmd_data    = held_nxt;
          wr_addr_nxt = wr_last ? '0 : wr_addr_r + 1'b1;
          if (wr_last) begin
            wrapped_nxt = 1'b1;
          end
        end
      end else if (armed_r && mode_r == srps_pkg::MODE_PLAYBACK) begin
        cmd_push = 1'b1;
        if (held_r != srps_pkg::NO_BYTE) begin
          cmd_kind = srps_pkg::CMD_SEND;
          cmd_data = held_r;
          held_nxt = srps_pkg::NO_BYTE;
        end else begin
          // never-written entries read back as erased
          cmd_kind    = (wrapped_r || rd_addr_r < wr_addr_r) ? srps_pkg::CMD_READ
                                                              : srps_pkg::CMD_SEND;
          cmd_addr    = rd_addr_r;
          cmd_data    = srps_pkg::ERASED_BYTE;
          rd_addr_nxt = rd_last ? '0 : rd_addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_code_r <= srps_pkg::TOGGLE_CODE_RST;
      play_code_r   <= srps_pkg::PLAY_CODE_RST;
      mode_r        <= srps_pkg::MODE_STOPPED;
      held_r        <= srps_pkg::NO_BYTE;
      wr_addr_r     <= '0;
      rd_addr_r     <= '0;
      wrapped_r     <= 1'b0;
      armed_r       <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      wr_addr_r <= wr_addr_nxt;
      rd_addr_r <= rd_addr_nxt;
      wrapped_r <= wrapped_nxt;
      armed_r   <= armed_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          srps_pkg::CFG_TOGGLE_IDX: toggle_code_r <= cfg_wdata;
          srps_pkg::CFG_PLAY_IDX:   play_code_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- src/srps_fifo.sv -----
// ----------------------------------------------------------------------------
// srps_fifo: two-entry command queue
// Decouples the classifier from the store side.
// ----------------------------------------------------------------------------
module srps_fifo #(
  parameter int unsigned WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- src/srps_back.sv -----
// ----------------------------------------------------------------------------
// srps_back: store and transmit side
// Owns the byte store; executes writes, reads, and drives the output word.
// ----------------------------------------------------------------------------
module srps_back #(
  parameter int unsigned STORE_DEPTH = 1024,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  srps_pkg::cmd_kind_t q_kind,
  input  logic [AW-1:0]       q_addr,
  input  logic [7:0]          q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_tx_byte
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;
  logic [7:0] s1_data_r;
  logic       s1_valid_r, s1_read_r;
  logic       out_valid_r;
  logic [7:0] out_tx_r;
  logic       out_free, s1_move, s1_ready, q_is_write;

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_move    = s1_valid_r && out_free;
  assign s1_ready   = !s1_valid_r || out_free;
  assign q_is_write = (q_kind == srps_pkg::CMD_WRITE);
  // writes retire at pop; sends/reads need a free read stage
  assign q_pop      = !q_empty && (q_is_write || s1_ready);

  always_ff @(posedge clk) begin
    if (q_pop && q_is_write) begin
      mem[q_addr] <= q_data;
    end
    if (q_pop && q_kind == srps_pkg::CMD_READ) begin
      rdata_r <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_is_write) begin
      s1_read_r <= (q_kind == srps_pkg::CMD_READ);
      s1_data_r <= q_data;
    end
    if (s1_move) begin
      out_tx_r <= s1_read_r ? rdata_r : s1_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && !q_is_write) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_r;

endmodule

// ----- src/serial_record_playback_store.sv -----
// ----------------------------------------------------------------------------
// serial_record_playback_store: serial record and playback byte store
// Classifies serial events (received byte / transmitter ready), records
// nonzero data bytes into a byte store and plays them back on ready ticks.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_operation,       | event word in
//          | in_rx_byte                              |
//  out     | out_valid, out_stall, out_tx_byte,      | tx word out
//          | out_mode_now                            |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | register write
//
//  Flow: one event word accepted per cycle unless in_stall; a tx word goes
//  through the queue slot, store read register and output register in turn.
//  Reset: synchronous, active low; the store needs no clearing pass - a fill
//  mark (write address plus wrap flag) makes unwritten entries read as 0xFF.
//  Stalls: in_stall rises only when the 2-deep command queue is full; a stalled
//  output holds its word while the classifier keeps running ahead.
// ----------------------------------------------------------------------------
module serial_record_playback_store #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic [1:0] out_mode_now
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned CMD_W = srps_pkg::CMD_KIND_W + AW + 8;

  logic                cmd_push, q_pop, q_empty, q_full, ev_take;
  srps_pkg::cmd_kind_t cmd_kind, q_kind;
  logic [AW-1:0]       cmd_addr, q_addr;
  logic [7:0]          cmd_data, q_data;
  logic [CMD_W-1:0]    q_head;

  // a full queue holds off every event, even ones that push nothing
  assign in_stall = q_full;
  assign ev_take  = in_valid && !q_full;

  srps_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .ev_take     (ev_take),
    .ev_operation(in_operation),
    .ev_rx_byte  (in_rx_byte),
    .cmd_push    (cmd_push),
    .cmd_kind    (cmd_kind),
    .cmd_addr    (cmd_addr),
    .cmd_data    (cmd_data)
  );

  srps_fifo #(.WIDTH(CMD_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data({cmd_kind, cmd_addr, cmd_data}),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  assign q_kind = srps_pkg::cmd_kind_t'(q_head[CMD_W-1 -: srps_pkg::CMD_KIND_W]);
  assign q_addr = q_head[8 +: AW];
  assign q_data = q_head[7:0];

  srps_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_kind     (q_kind),
    .q_addr     (q_addr),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tx_byte(out_tx_byte)
  );

  // tx words only come from playback ticks
  assign out_mode_now = srps_pkg::MODE_PLAYBACK;

endmodule

// ----- test/srps_checker.sv -----
// ----------------------------------------------------------------------------
// srps_checker: scoreboard for the serial record/playback store
// Watches the register port and both word channels, keeps its own copy of
// the mode, held byte, addresses and byte store, and compares every tx word
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module srps_checker
  import srps_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_tx_byte,
  input  logic [1:0] out_mode_now,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] tx_byte;
    mode_t      mode_now;
  } tx_word_t;

  tx_word_t    tx_expected_q[$];
  logic [7:0]  toggle_code;
  logic [7:0]  play_code;
  mode_t       mode_r;
  logic [7:0]  held_byte;
  int unsigned wr_addr;
  int unsigned rd_addr;
  logic        armed;
  logic [7:0]  shadow_store[STORE_DEPTH];
  int          mismatches;

  // one accepted event word through the shadow store
  task automatic step_store_model(input logic op, input logic [7:0] b);
    tx_word_t w;
    if (op == 1'b0) begin
      held_byte = b;
      if (b == toggle_code) begin
        mode_r    = (mode_r == MODE_RECORDING) ? MODE_STOPPED : MODE_RECORDING;
        held_byte = NO_BYTE;
      end else if (b == play_code && mode_r != MODE_PLAYBACK) begin
        mode_r    = MODE_PLAYBACK;
        held_byte = NO_BYTE;
      end
      if (held_byte != NO_BYTE && mode_r == MODE_RECORDING) begin
        shadow_store[wr_addr] = held_byte;
        wr_addr = (wr_addr + 1) % STORE_DEPTH;
      end
      armed = 1'b1;
    end else if (armed && mode_r == MODE_PLAYBACK) begin
      if (held_byte != NO_BYTE) begin
        w.tx_byte = held_byte;
        held_byte = NO_BYTE;
      end else begin
        w.tx_byte = shadow_store[rd_addr];
        rd_addr   = (rd_addr + 1) % STORE_DEPTH;
      end
      w.mode_now = mode_r;
      tx_expected_q.push_back(w);
    end
  endtask

  task automatic note_mismatch(input string field, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("tx word mismatch on %s: expected %0h, got %0h", field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    tx_word_t w;
    if (!rst_n) begin
      toggle_code = TOGGLE_CODE_RST;
      play_code   = PLAY_CODE_RST;
      mode_r      = MODE_STOPPED;
      held_byte   = NO_BYTE;
      wr_addr     = 0;
      rd_addr     = 0;
      armed       = 1'b0;
      mismatches  = 0;
      for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = ERASED_BYTE;
      tx_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOGGLE_IDX: toggle_code = cfg_wdata;
          CFG_PLAY_IDX:   play_code = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) step_store_model(in_operation, in_rx_byte);
      if (out_valid && !out_stall) begin
        if (tx_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected tx word: byte %0h mode %0d", out_tx_byte, out_mode_now);
        end else begin
          w = tx_expected_q.pop_front();
          if (out_tx_byte !== w.tx_byte)
            note_mismatch("tx_byte", int'(w.tx_byte), int'(out_tx_byte));
          if (out_mode_now !== w.mode_now)
            note_mismatch("mode_now", int'(w.mode_now), int'(out_mode_now));
        end
      end
    end
    pending    <= tx_expected_q.size();
    fail_count <= mismatches;
  end

endmodule

// ----- test/tb_serial_record_playback_store.sv -----
// ----------------------------------------------------------------------------
// tb_serial_record_playback_store: testbench top for the record/playback store
// Drives event words and register writes, stalls the tx side at random, and
// gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_serial_record_playback_store;
  timeunit 1ns;
  timeprecision 1ps;
  import srps_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_WORDS = 70;   // random words per idle phase
  localparam int          HOLD_CYCLES = 300;  // long tx hold-off

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic       in_operation;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_tx_byte;
  logic [1:0] out_mode_now;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        pressure_req;
  int          cycle_count;

  // codes currently loaded, so the stimulus can build well-formed sessions
  logic [7:0] cur_toggle;
  logic [7:0] cur_play;

  serial_record_playback_store #(
    .STORE_DEPTH(DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_mode_now(out_mode_now)
  );

  srps_checker #(
    .STORE_DEPTH(DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_mode_now(out_mode_now),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // tx side: random stalls, plus one long hold-off once the pressure phase
  // asks for it, so the queue fills and the event side gets stalled
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one event word. Called at a falling edge, returns at a falling
  // edge with in_valid still high, so back-to-back words keep valid up.
  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // ready tick; the byte field is a don't-care, keep it moving
  task automatic send_tick();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    send_word(1'b1, junk);
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if ($urandom_range(15) == 0) v = NO_BYTE;
    return v;
  endfunction

  // drop valid and wait for the last tx word, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // both registers, back to back; only called once drained
  task automatic load_codes(input logic [7:0] toggle, input logic [7:0] play);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOGGLE_IDX;
    cfg_wdata <= toggle;
    @(negedge clk);
    cfg_index <= CFG_PLAY_IDX;
    cfg_wdata <= play;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_toggle = toggle;
    cur_play   = play;
    @(negedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 76; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 76; end
      default: begin send_idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // Random sessions: mostly record takes and playback runs built from the
  // loaded codes, the rest raw noise.
  task automatic run_sessions(input int n);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        // play code then toggle lands in recording from any mode, if the codes differ
        send_word(1'b0, cur_play);
        send_word(1'b0, cur_toggle);
        len = $urandom_range(1, 24);
        repeat (len) send_word(1'b0, data_byte());
        sent += len + 2;
      end else if (kind < 8) begin
        // playback run, with a few data bytes held in between ticks
        send_word(1'b0, cur_play);
        len = $urandom_range(1, 24);
        repeat (len) begin
          if ($urandom_range(7) == 0) send_word(1'b0, data_byte());
          else send_tick();
        end
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        sent += len;
      end
    end
  endtask

  initial begin
    logic [7:0] rt;
    logic [7:0] rp;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TOGGLE_IDX;
    cfg_wdata     = 8'h00;
    in_valid      = 1'b0;
    in_operation  = 1'b0;
    in_rx_byte    = 8'h00;
    send_idle_pct = 0;
    stall_pct     = 0;
    pressure_req  = 1'b0;
    cur_toggle    = TOGGLE_CODE_RST;
    cur_play      = PLAY_CODE_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset codes. Store indexes noted per tick.
    send_tick();                   // tick before any byte: ignored
    send_word(1'b0, NO_BYTE);      // zero byte arms ticks, holds nothing
    send_tick();                   // tick while stopped: ignored
    send_word(1'b0, cur_toggle);   // -> recording
    send_word(1'b0, 8'hFF);        // [0]
    send_word(1'b0, 8'h01);        // [1]
    send_word(1'b0, 8'h80);        // [2]
    send_word(1'b0, NO_BYTE);      // zero is never stored
    send_word(1'b0, 8'h55);        // [3]
    send_word(1'b0, cur_play);     // -> playback
    send_tick();                   // reads [0]
    send_tick();                   // reads [1]
    send_word(1'b0, cur_play);     // play code in playback is held data
    send_tick();                   // sends held play code
    send_word(1'b0, 8'h42);
    send_tick();                   // sends held byte
    send_tick();                   // reads [2]
    send_tick();                   // reads [3]
    send_tick();                   // reads an erased entry
    send_word(1'b0, cur_toggle);   // playback -> recording
    send_word(1'b0, 8'h7E);        // [4]
    send_word(1'b0, cur_toggle);   // -> stopped
    send_tick();                   // ignored
    send_word(1'b0, cur_play);     // stopped -> playback
    send_tick();                   // reads [5], erased

    // Random sessions under several code settings, extremes and equal
    // codes (toggle must win) among them, each across all idle phases.
    for (int s = 0; s < 5; s++) begin
      drain();
      case (s)
        0: load_codes(TOGGLE_CODE_RST, PLAY_CODE_RST);
        1: load_codes(8'h00, 8'hFF);
        2: load_codes(8'hFF, 8'h00);
        3: load_codes(8'h5A, 8'h5A);
        default: begin
          rt = 8'($urandom_range(255));
          rp = 8'($urandom_range(255));
          load_codes(rt, rp);
        end
      endcase
      for (int p = 0; p < 4; p++) begin
        set_idling(p);
        run_sessions(PHASE_WORDS);
      end
    end

    // Pressure: tx side held off for a long stretch while ticks keep
    // coming, so the command queue fills and in_stall has to rise.
    drain();
    load_codes(TOGGLE_CODE_RST, PLAY_CODE_RST);
    set_idling(0);
    pressure_req <= 1'b1;
    send_word(1'b0, cur_play);
    repeat (120) send_tick();

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/srps_pkg.sv
src/srps_front.sv
src/srps_fifo.sv
src/srps_back.sv
src/serial_record_playback_store.sv
test/srps_checker.sv
test/tb_serial_record_playback_store.sv
